// File: rtl/mcsm_pkg.sv
// Shared types and codes of the MCS-M minimal triangulation block.
package mcsm_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_RUN    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int W_W = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL_LOAD,
        ST_SEL_SCAN,
        ST_MARK,
        ST_SRCH_LOAD,
        ST_SRCH_SCAN,
        ST_FILL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       clear_graph;
        logic       add_edge;
        logic [4:0] node_a;
        logic [4:0] node_b;
        logic       run_init;
        logic       tok_load;
        logic       mark;
        logic       relax;
        logic       commit;
    } ctl_t;

endpackage

// File: rtl/mcsm_cell.sv
// One vertex cell: adjacency row, weight, search label and a token stage of the ring.
module mcsm_cell #(
    parameter int MAX_VERTICES = 32,
    parameter int CELL_ID      = 0
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mcsm_pkg::ctl_t                        ctl,
    input  logic [$clog2(MAX_VERTICES)-1:0]       sel_v,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]     cnt_n,
    input  logic [MAX_VERTICES-1:0]               fill_vec,
    input  logic [$clog2(MAX_VERTICES)-1:0]       tin_idx,
    input  logic [mcsm_pkg::W_W-1:0]              tin_pm,
    input  logic                                  tin_reach,
    input  logic [mcsm_pkg::W_W-1:0]              tin_w,
    input  logic                                  tin_num,
    output logic [$clog2(MAX_VERTICES)-1:0]       tout_idx,
    output logic [mcsm_pkg::W_W-1:0]              tout_pm,
    output logic                                  tout_reach,
    output logic [mcsm_pkg::W_W-1:0]              tout_w,
    output logic                                  tout_num,
    output logic [MAX_VERTICES-1:0]               row_out,
    output logic                                  fill_out,
    output logic                                  upd_out
);
    import mcsm_pkg::*;

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [MAX_VERTICES-1:0] row_reg, row_next;
    logic [W_W-1:0]          w_reg, pm_reg, ti_reg, tp_reg, tw_reg;
    logic [IW-1:0]           tidx_reg;
    logic                    num_reg, reach_reg, fill_reg, tr_reg, tn_reg;
    logic                    active, is_v, hit, below, upd;
    logic [W_W-1:0]          t_val;

    assign active = cnt_n > CW'(CELL_ID);
    assign is_v   = sel_v == IW'(CELL_ID);
    assign hit    = ctl.relax && active && !num_reg && tr_reg && row_reg[tidx_reg]
                    && (tidx_reg != IW'(CELL_ID));
    assign below  = tp_reg < w_reg;
    assign t_val  = below ? w_reg : tp_reg;
    assign upd    = hit && (!reach_reg || (t_val < pm_reg));

    always_comb begin
        row_next = row_reg;
        if (ctl.clear_graph) begin
            row_next = '0;
        end
        if (ctl.add_edge && (ctl.node_a != ctl.node_b)) begin
            for (int k = 0; k < MAX_VERTICES; k++) begin
                if (int'(ctl.node_a) == CELL_ID && int'(ctl.node_b) == k) begin
                    row_next[k] = 1'b1;
                end
                if (int'(ctl.node_b) == CELL_ID && int'(ctl.node_a) == k) begin
                    row_next[k] = 1'b1;
                end
            end
        end
        if (ctl.commit) begin
            if (is_v) begin
                row_next = row_next | fill_vec;
            end
            if (fill_reg) begin
                row_next[sel_v] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            w_reg     <= '0;
            num_reg   <= 1'b0;
            reach_reg <= 1'b0;
            fill_reg  <= 1'b0;
            pm_reg    <= '0;
        end else begin
            row_reg <= row_next;
            if (ctl.run_init) begin
                w_reg   <= '0;
                num_reg <= 1'b0;
            end
            if (ctl.mark) begin
                fill_reg <= 1'b0;
                if (is_v) begin
                    num_reg   <= 1'b1;
                    pm_reg    <= '0;
                    reach_reg <= 1'b1;
                end else begin
                    reach_reg <= 1'b0;
                end
            end
            if (upd) begin
                pm_reg    <= t_val;
                reach_reg <= 1'b1;
            end
            if (hit && below) begin
                fill_reg <= 1'b1;
            end
            if (ctl.commit && active && !num_reg && (row_reg[sel_v] || fill_reg)) begin
                w_reg <= w_reg + 1'b1;
            end
        end
    end

    // Token stage of the ring: loads this cell's own label or passes the neighbor's on.
    always_ff @(posedge aclk) begin
        if (ctl.tok_load) begin
            tidx_reg <= IW'(CELL_ID);
            tp_reg   <= pm_reg;
            tr_reg   <= reach_reg;
            tw_reg   <= w_reg;
            tn_reg   <= num_reg;
        end else begin
            tidx_reg <= tin_idx;
            tp_reg   <= tin_pm;
            tr_reg   <= tin_reach;
            tw_reg   <= tin_w;
            tn_reg   <= tin_num;
        end
    end

    assign ti_reg     = tw_reg;
    assign tout_idx   = tidx_reg;
    assign tout_pm    = tp_reg;
    assign tout_reach = tr_reg;
    assign tout_w     = ti_reg;
    assign tout_num   = tn_reg;
    assign row_out    = row_reg;
    assign fill_out   = fill_reg;
    assign upd_out    = upd;

endmodule

// File: rtl/mcs_m_minimal_triangulation_top.sv
// Top level of the MCS-M minimal triangulation engine: controller and ring of vertex cells.
// Edge loads and clears are accepted back to back while idle. A run numbers n vertices;
// each choice is a full pass of the token ring, and each fill search after it takes rounds
// of the ring until a round changes no label, at most n+1 rounds, with a mark state before
// the search and a commit of the fill edges after it. The n results then stream out one
// per cycle while m_tready accepts them. Fill edges stay in the graph for later runs.
module mcs_m_minimal_triangulation_top #(
    parameter int MAX_VERTICES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // node_a [4:0], node_b [9:5], zero [15:10]
    input  logic [1:0]  s_tuser,   // operation [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // order_position [4:0], vertex [9:5], neighbor_row [41:10]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data   // vertex_count [5:0]
);
    import mcsm_pkg::*;

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [IW-1:0] CNT_LAST = IW'(MAX_VERTICES - 1);

    state_t state_reg, state_next;
    ctl_t   ctl;

    logic [5:0]    vc_reg;
    logic [CW-1:0] n_cnt, pos_reg, p_reg;
    logic [IW-1:0] cnt_reg, best_idx_reg;
    logic [W_W-1:0] best_w_reg;
    logic          found_reg, chg_reg;
    logic [IW-1:0] order_reg [MAX_VERTICES];

    logic [IW-1:0]           tk_idx   [MAX_VERTICES];
    logic [W_W-1:0]          tk_pm    [MAX_VERTICES];
    logic                    tk_reach [MAX_VERTICES];
    logic [W_W-1:0]          tk_w     [MAX_VERTICES];
    logic                    tk_num   [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] rows     [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] fill_vec, upd_vec, in_use, emit_row;

    logic        m_valid_reg, m_last_reg, em_go, take_tail, s_acc;
    logic [4:0]  m_pos_reg, m_vtx_reg;
    logic [31:0] m_row_reg;
    logic [IW-1:0] emit_v;

    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (vc_reg == 6'd0) begin
            n_cnt = CW'(1);
        end else if (int'(vc_reg) > MAX_VERTICES) begin
            n_cnt = CW'(MAX_VERTICES);
        end else begin
            n_cnt = CW'(vc_reg);
        end
        for (int k = 0; k < MAX_VERTICES; k++) begin
            in_use[k] = n_cnt > CW'(k);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_VERTICES; gi++) begin : g_ring
            localparam int PREV = (gi == 0) ? MAX_VERTICES - 1 : gi - 1;
            mcsm_cell #(
                .MAX_VERTICES(MAX_VERTICES),
                .CELL_ID     (gi)
            ) u_vcell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .sel_v     (best_idx_reg),
                .cnt_n     (n_cnt),
                .fill_vec  (fill_vec),
                .tin_idx   (tk_idx[PREV]),
                .tin_pm    (tk_pm[PREV]),
                .tin_reach (tk_reach[PREV]),
                .tin_w     (tk_w[PREV]),
                .tin_num   (tk_num[PREV]),
                .tout_idx  (tk_idx[gi]),
                .tout_pm   (tk_pm[gi]),
                .tout_reach(tk_reach[gi]),
                .tout_w    (tk_w[gi]),
                .tout_num  (tk_num[gi]),
                .row_out   (rows[gi]),
                .fill_out  (fill_vec[gi]),
                .upd_out   (upd_vec[gi])
            );
        end
    endgenerate

    // The tail of the ring shows the cells in descending index order, so a tie goes to
    // the later, lower-indexed candidate.
    assign take_tail = (n_cnt > CW'(tk_idx[MAX_VERTICES-1])) && !tk_num[MAX_VERTICES-1]
                       && (!found_reg || (tk_w[MAX_VERTICES-1] >= best_w_reg));

    assign emit_v   = order_reg[p_reg[IW-1:0]];
    assign emit_row = rows[emit_v] & in_use;
    assign em_go    = (state_reg == ST_EMIT) && (p_reg != n_cnt) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_tuser == OP_RUN) begin
                    state_next = ST_SEL_LOAD;
                end
            end
            ST_SEL_LOAD: state_next = ST_SEL_SCAN;
            ST_SEL_SCAN: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK: state_next = (pos_reg == CW'(1)) ? ST_EMIT : ST_SRCH_LOAD;
            ST_SRCH_LOAD: state_next = ST_SRCH_SCAN;
            ST_SRCH_SCAN: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = (chg_reg || (|upd_vec)) ? ST_SRCH_LOAD : ST_FILL;
                end
            end
            ST_FILL: state_next = ST_SEL_LOAD;
            ST_EMIT: begin
                if ((p_reg == n_cnt) && (!m_valid_reg || m_tready)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl             = '0;
        s_tready        = state_reg == ST_IDLE;
        ctl.node_a      = s_tdata[4:0];
        ctl.node_b      = s_tdata[9:5];
        ctl.clear_graph = s_acc && s_tuser == OP_CLEAR;
        ctl.add_edge    = s_acc && s_tuser == OP_ADD;
        ctl.run_init    = s_acc && s_tuser == OP_RUN;
        ctl.tok_load    = state_reg == ST_SEL_LOAD || state_reg == ST_SRCH_LOAD;
        ctl.mark        = state_reg == ST_MARK;
        ctl.relax       = state_reg == ST_SRCH_SCAN;
        ctl.commit      = state_reg == ST_FILL;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vc_reg      <= 6'd32;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            p_reg       <= '0;
            found_reg   <= 1'b0;
            chg_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                vc_reg <= cfg_data;
            end
            if (ctl.tok_load) begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
                chg_reg   <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == ST_SEL_SCAN && take_tail) begin
                found_reg <= 1'b1;
            end
            if (state_reg == ST_SRCH_SCAN && (|upd_vec)) begin
                chg_reg <= 1'b1;
            end
            if (ctl.run_init) begin
                pos_reg <= n_cnt;
                p_reg   <= '0;
            end
            if (ctl.commit) begin
                pos_reg <= pos_reg - 1'b1;
            end
            if (em_go) begin
                p_reg       <= p_reg + 1'b1;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SEL_SCAN && take_tail) begin
            best_idx_reg <= tk_idx[MAX_VERTICES-1];
            best_w_reg   <= tk_w[MAX_VERTICES-1];
        end
        if (ctl.mark) begin
            order_reg[pos_reg[IW-1:0] - 1'b1] <= best_idx_reg;
        end
        if (em_go) begin
            m_pos_reg  <= 5'(p_reg);
            m_vtx_reg  <= 5'(emit_v);
            m_last_reg <= (p_reg + 1'b1) == n_cnt;
            for (int k = 0; k < 32; k++) begin
                if (k < MAX_VERTICES) begin
                    m_row_reg[k] <= emit_row[k];
                end else begin
                    m_row_reg[k] <= 1'b0;
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'd0, m_row_reg, m_vtx_reg, m_pos_reg};

`ifndef SYNTHESIS
    a_out_only_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> state_reg == ST_EMIT)
        else $error("result valid outside the emit phase");
    a_in_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_valid_reg)
        else $error("input taken while a result is pending");
    a_last_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> p_reg == n_cnt)
        else $error("last result flagged before the run's end");
`endif

endmodule
